### hdl/rti_pkg.sv
// ============================================================================
// rti_pkg: shared types and constants for the ray/triangle intersector
// Request layouts, flag bundle and fixed widths used across the pipeline.
// ============================================================================
package rti_pkg;

  localparam int VEC_W     = 63;  // packed x,y,z vector field
  localparam int DIST_W    = 32;  // distance, unsigned Q16.16
  localparam int DIST_FRAC = 16;
  localparam int GIVEN_W   = 3;

  // Normalizer widths: prescaled magnitudes stay below 2^30.
  localparam int PRE_W  = 30;
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;
  localparam int RT_W   = 63;   // working width of the square root stages

  typedef struct packed {
    logic [VEC_W-1:0]   ray_origin;
    logic [VEC_W-1:0]   ray_dir;
    logic [VEC_W-1:0]   vertex_a;
    logic [VEC_W-1:0]   vertex_b;
    logic [VEC_W-1:0]   vertex_c;
    logic [VEC_W-1:0]   normal_a;
    logic [VEC_W-1:0]   normal_b;
    logic [VEC_W-1:0]   normal_c;
    logic [GIVEN_W-1:0] normal_given;
  } rti_in_t;

  typedef struct packed {
    logic               hit;
    logic [DIST_W-1:0]  distance;
    logic [VEC_W-1:0]   surface_normal;
  } rti_out_t;

  typedef struct packed {
    logic hit;
    logic sat;
  } rti_flag_t;

endpackage

### hdl/rti_dly.sv
// ============================================================================
// rti_dly: enabled delay line
// Shifts a word through N registers, advancing only when the pipeline moves.
// ============================================================================
module rti_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q_o = sr_r[N-1];

endmodule

### hdl/rti_div.sv
// ============================================================================
// rti_div: pipelined restoring divider
// One quotient bit per stage; the starting remainder must be below the divisor.
// ============================================================================
module rti_div #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] dv_i,
  output logic [QW-1:0] q_o
);

  logic [DW-1:0] rem_s [QW+1];
  logic [DW-1:0] dv_s  [QW+1];
  logic [QW-1:0] lo_s  [QW+1];
  logic [QW-1:0] q_s   [QW+1];

  assign rem_s[0] = rem_i;
  assign dv_s[0]  = dv_i;
  assign lo_s[0]  = lo_i;
  assign q_s[0]   = '0;

  for (genvar gi = 0; gi < QW; gi++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] rem_r;
    logic [DW-1:0] dv_r;
    logic [QW-1:0] lo_r;
    logic [QW-1:0] q_r;

    always_comb begin
      trial = {rem_s[gi], lo_s[gi][QW-1]};
      diff  = trial - {1'b0, dv_s[gi]};
      take  = trial >= {1'b0, dv_s[gi]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= take ? diff[DW-1:0] : trial[DW-1:0];
        dv_r  <= dv_s[gi];
        lo_r  <= lo_s[gi] << 1;
        q_r   <= {q_s[gi][QW-2:0], take};
      end
    end

    assign rem_s[gi+1] = rem_r;
    assign dv_s[gi+1]  = dv_r;
    assign lo_s[gi+1]  = lo_r;
    assign q_s[gi+1]   = q_r;
  end

  assign q_o = q_s[QW];

endmodule

### hdl/rti_isqrt.sv
// ============================================================================
// rti_isqrt: pipelined integer square root
// Digit-by-digit floor square root, one result bit per stage.
// ============================================================================
module rti_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rti_pkg::SUM_W-1:0]  x_i,
  output logic [rti_pkg::ROOT_W-1:0] root_o
);

  import rti_pkg::*;

  logic [RT_W-1:0] x_s [ROOT_W+1];
  logic [RT_W-1:0] r_s [ROOT_W+1];

  assign x_s[0] = RT_W'(x_i);
  assign r_s[0] = '0;

  for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_stage
    localparam int SH = 2 * (ROOT_W - 1 - gi);
    logic [RT_W-1:0] bitv;
    logic [RT_W-1:0] trial;
    logic            ge;
    logic [RT_W-1:0] x_r;
    logic [RT_W-1:0] r_r;

    always_comb begin
      bitv  = RT_W'(1) << SH;
      trial = r_s[gi] + bitv;
      ge    = x_s[gi] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r <= ge ? (x_s[gi] - trial) : x_s[gi];
        r_r <= ge ? ((r_s[gi] >> 1) + bitv) : (r_s[gi] >> 1);
      end
    end

    assign x_s[gi+1] = x_r;
    assign r_s[gi+1] = r_r;
  end

  assign root_o = r_s[ROOT_W][ROOT_W-1:0];

endmodule

### hdl/rti_nrm.sv
// ============================================================================
// rti_nrm: pipelined vector normalizer
// Prescales, sums squares, takes the root and divides each lane by it.
// ============================================================================
module rti_nrm #(
  parameter int IW = 21,
  parameter int F  = 18
) (
  input  logic                clk,
  input  logic                en,
  input  logic [3*IW-1:0]     vec_i,
  output logic [3*(F+2)-1:0]  nrm_o
);

  import rti_pkg::*;

  localparam int NQ = F + 2;
  localparam int WQ = F + 1;
  localparam int MW = (IW > PRE_W) ? IW : PRE_W;
  localparam int SW = $clog2(MW + 1);
  localparam int M_DLY = ROOT_W + 2;

  logic [2:0][IW-1:0]    mag;
  logic [MW-1:0]         mx;
  logic [SW-1:0]         sh;
  logic [2:0][PRE_W-1:0] m_nxt;
  logic [2:0]            sg_nxt;

  always_comb begin
    mx = '0;
    sh = '0;
    for (int k = 0; k < 3; k++) begin
      sg_nxt[k] = vec_i[k*IW + IW - 1];
      mag[k]    = sg_nxt[k] ? (IW'(0) - vec_i[k*IW +: IW]) : vec_i[k*IW +: IW];
      if (MW'(mag[k]) > mx) begin
        mx = MW'(mag[k]);
      end
    end
    for (int i = PRE_W; i < MW; i++) begin
      if (mx[i]) begin
        sh = SW'(i - PRE_W + 1);
      end
    end
    for (int k = 0; k < 3; k++) begin
      m_nxt[k] = PRE_W'(MW'(mag[k]) >> sh);
    end
  end

  logic [2:0][PRE_W-1:0]   m_r;
  logic [2:0]              sg_r;
  logic [2:0][2*PRE_W-1:0] sq_r;
  logic [SUM_W-1:0]        sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r   <= m_nxt;
      sg_r  <= sg_nxt;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= m_r[k] * m_r[k];
      end
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  logic [ROOT_W-1:0] root;

  rti_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .x_i    (sum_r),
    .root_o (root)
  );

  logic [2:0][PRE_W-1:0] m_d;
  logic [2:0]            sg_d;

  rti_dly #(.W(3*PRE_W + 3), .N(M_DLY)) u_m_dly (
    .clk (clk),
    .en  (en),
    .d_i ({sg_r, m_r}),
    .q_o ({sg_d, m_d})
  );

  logic [2:0][WQ-1:0] q;

  for (genvar gk = 0; gk < 3; gk++) begin : g_div
    rti_div #(.DW(ROOT_W), .QW(WQ)) u_div (
      .clk   (clk),
      .en    (en),
      .rem_i (ROOT_W'(m_d[gk] >> 1)),
      .lo_i  ({m_d[gk][0], {F{1'b0}}}),
      .dv_i  (root),
      .q_o   (q[gk])
    );
  end

  logic [2:0] sg_q;
  logic       zero_q;

  rti_dly #(.W(4), .N(WQ)) u_sg_dly (
    .clk (clk),
    .en  (en),
    .d_i ({sg_d, root == '0}),
    .q_o ({sg_q, zero_q})
  );

  logic [2:0][NQ-1:0] nrm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (zero_q) begin
          nrm_r[k] <= '0;
        end else if (sg_q[k]) begin
          nrm_r[k] <= NQ'(0) - NQ'(q[k]);
        end else begin
          nrm_r[k] <= NQ'(q[k]);
        end
      end
    end
  end

  assign nrm_o = nrm_r;

endmodule

### hdl/rti_geom.sv
// ============================================================================
// rti_geom: edge, cross and dot product pipeline with the hit decision
// Six stages from the corners and the ray to determinant, numerators and flags.
// ============================================================================
module rti_geom #(
  parameter int C = 21
) (
  input  logic                   clk,
  input  logic                   en,
  input  rti_pkg::rti_in_t       in_i,
  output logic [3*(2*C+3)-1:0]   n_o,
  output rti_pkg::rti_flag_t     flag_o,
  output logic [3*C+4:0]         ad_o,
  output logic [3*C+5:0]         abn_o,
  output logic [3*C+4:0]         au_o,
  output logic [3*C+4:0]         av_o
);

  import rti_pkg::*;

  localparam int E   = C + 1;
  localparam int PW  = 2 * E;
  localparam int NW  = 2 * E + 1;
  localparam int DDW = C + NW + 2;
  localparam int BNW = E + NW + 2;
  localparam int CW  = (BNW > DDW + DIST_FRAC) ? BNW : DDW + DIST_FRAC;

  // Stage 1: edges and the corner-to-origin vector.
  logic signed [C-1:0] o_c [3];
  logic signed [C-1:0] a_c [3];
  logic signed [C-1:0] b_c [3];
  logic signed [C-1:0] c_c [3];
  logic signed [C-1:0] dir_c [3];
  logic signed [E-1:0] e1_r [3];
  logic signed [E-1:0] e2_r [3];
  logic signed [E-1:0] bv_r [3];
  logic signed [C-1:0] dir_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o_c[k]   = $signed(in_i.ray_origin[k*C +: C]);
      a_c[k]   = $signed(in_i.vertex_a[k*C +: C]);
      b_c[k]   = $signed(in_i.vertex_b[k*C +: C]);
      c_c[k]   = $signed(in_i.vertex_c[k*C +: C]);
      dir_c[k] = $signed(in_i.ray_dir[k*C +: C]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k]  <= E'(a_c[k]) - E'(b_c[k]);
        e2_r[k]  <= E'(a_c[k]) - E'(c_c[k]);
        bv_r[k]  <= E'(a_c[k]) - E'(o_c[k]);
        dir_r[k] <= dir_c[k];
      end
    end
  end

  // Stage 2: the six products of each of the three cross products.
  logic signed [PW-1:0] pn_r [3][2];
  logic signed [PW-1:0] pu_r [3][2];
  logic signed [PW-1:0] pv_r [3][2];
  logic signed [E-1:0]  bv2_r [3];
  logic signed [C-1:0]  dir2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pn_r[k][0] <= e1_r[(k+1)%3] * e2_r[(k+2)%3];
        pn_r[k][1] <= e1_r[(k+2)%3] * e2_r[(k+1)%3];
        pu_r[k][0] <= bv_r[(k+1)%3] * e2_r[(k+2)%3];
        pu_r[k][1] <= bv_r[(k+2)%3] * e2_r[(k+1)%3];
        pv_r[k][0] <= e1_r[(k+1)%3] * bv_r[(k+2)%3];
        pv_r[k][1] <= e1_r[(k+2)%3] * bv_r[(k+1)%3];
        bv2_r[k]   <= bv_r[k];
        dir2_r[k]  <= dir_r[k];
      end
    end
  end

  // Stage 3: face normal and the two numerator vectors.
  logic signed [NW-1:0] n_r [3];
  logic signed [NW-1:0] cu_r [3];
  logic signed [NW-1:0] cv_r [3];
  logic signed [E-1:0]  bv3_r [3];
  logic signed [C-1:0]  dir3_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k]    <= NW'(pn_r[k][0]) - NW'(pn_r[k][1]);
        cu_r[k]   <= NW'(pu_r[k][0]) - NW'(pu_r[k][1]);
        cv_r[k]   <= NW'(pv_r[k][0]) - NW'(pv_r[k][1]);
        bv3_r[k]  <= bv2_r[k];
        dir3_r[k] <= dir2_r[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_o[k*NW +: NW] = n_r[k];
    end
  end

  // Stage 4: dot product terms.
  logic signed [C+NW-1:0] td_r [3];
  logic signed [C+NW-1:0] tu_r [3];
  logic signed [C+NW-1:0] tv_r [3];
  logic signed [E+NW-1:0] tb_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        td_r[k] <= dir3_r[k] * n_r[k];
        tu_r[k] <= dir3_r[k] * cu_r[k];
        tv_r[k] <= dir3_r[k] * cv_r[k];
        tb_r[k] <= bv3_r[k] * n_r[k];
      end
    end
  end

  // Stage 5: determinant, numerators and distance numerator.
  logic signed [DDW-1:0] d_r;
  logic signed [DDW-1:0] u_r;
  logic signed [DDW-1:0] v_r;
  logic signed [BNW-1:0] bn_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= DDW'(td_r[0]) + DDW'(td_r[1]) + DDW'(td_r[2]);
      u_r  <= DDW'(tu_r[0]) + DDW'(tu_r[1]) + DDW'(tu_r[2]);
      v_r  <= DDW'(tv_r[0]) + DDW'(tv_r[1]) + DDW'(tv_r[2]);
      bn_r <= BNW'(tb_r[0]) + BNW'(tb_r[1]) + BNW'(tb_r[2]);
    end
  end

  // Stage 6: range tests, mirrored for a negative determinant.
  logic signed [DDW:0] uv;
  logic signed [DDW:0] d_ext;
  logic                pos;
  logic                in_rng;
  logic                bn_ok;
  rti_flag_t           flag_nxt;
  logic [DDW-1:0]      ad_nxt;
  logic [BNW-1:0]      abn_nxt;

  always_comb begin
    uv     = (DDW+1)'(u_r) + (DDW+1)'(v_r);
    d_ext  = (DDW+1)'(d_r);
    pos    = !d_r[DDW-1];
    if (pos) begin
      in_rng = (u_r >= 0) && (u_r <= d_r) && (v_r >= 0) && (uv <= d_ext);
    end else begin
      in_rng = (u_r <= 0) && (u_r >= d_r) && (v_r <= 0) && (uv >= d_ext);
    end
    bn_ok        = (bn_r == '0) || (bn_r[BNW-1] == d_r[DDW-1]);
    flag_nxt.hit = (d_r != '0) && in_rng && bn_ok;
    ad_nxt       = pos ? d_r : (DDW'(0) - d_r);
    abn_nxt      = bn_r[BNW-1] ? (BNW'(0) - bn_r) : bn_r;
    flag_nxt.sat = CW'(abn_nxt) >= CW'({ad_nxt, {DIST_FRAC{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag_o <= flag_nxt;
      ad_o   <= ad_nxt;
      abn_o  <= abn_nxt;
      au_o   <= u_r[DDW-1] ? (DDW'(0) - u_r) : u_r;
      av_o   <= v_r[DDW-1] ? (DDW'(0) - v_r) : v_r;
    end
  end

endmodule

### hdl/ray_triangle_intersect_top.sv
// ============================================================================
// ray_triangle_intersect_top: pipelined ray/triangle intersection
// Cramer's-rule hit test with distance and interpolated shading normal.
// ============================================================================
// Throughput: one request per cycle while the skid register is empty; the
// normalizer's square root and divider stages set the depth, and all stages move together.
// Reset clears all valid bits, including those of the output and skid
// registers; data registers keep whatever they held.
module ray_triangle_intersect_top #(
  parameter int COORD_BITS = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rti_pkg::rti_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rti_pkg::rti_out_t out_data
);

  import rti_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = C - 3;        // fraction bits of the normals
  localparam int E   = C + 1;
  localparam int NW  = 2 * E + 1;    // face normal lane width
  localparam int DDW = C + NW + 2;   // determinant and numerators
  localparam int BNW = E + NW + 2;   // distance numerator
  localparam int NQ  = F + 2;        // signed normalized lane
  localparam int WQ  = F + 1;        // barycentric weight
  localparam int PRW = WQ + 1 + NQ;  // weight times normal

  // Pipeline timing, counted in register stages after acceptance.
  localparam int GEO_LAT = 6;                    // geometry results
  localparam int N_TAP   = 3;                    // face normal leaves geometry
  localparam int LN_TOT  = N_TAP + 36 + F;       // all normalized vectors ready
  localparam int T_END   = LN_TOT + 3;           // blend, last pipeline stage
  localparam int FLG_DLY = T_END - 1 - GEO_LAT;
  localparam int Q_DLY   = T_END - 1 - GEO_LAT - DIST_W;
  localparam int WT_DLY  = LN_TOT - GEO_LAT - WQ;

  // The whole pipeline moves together; it halts only when the skid
  // register behind the output register is occupied.
  logic     en;
  logic     acc;
  logic     sk_vld_r;
  logic     out_vld_r;
  rti_out_t sk_data_r;
  rti_out_t out_data_r;

  assign en       = !sk_vld_r;
  assign in_stall = sk_vld_r;
  assign acc      = in_valid && en;

  logic [T_END-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[T_END-2:0], acc};
    end
  end

  // Geometry: edges, cross products, determinant and hit decision.
  logic [3*NW-1:0] face_n;
  rti_flag_t       flag;
  logic [DDW-1:0]  ad;
  logic [BNW-1:0]  abn;
  logic [DDW-1:0]  au;
  logic [DDW-1:0]  av;

  rti_geom #(.C(C)) u_geom (
    .clk    (clk),
    .en     (en),
    .in_i   (in_data),
    .n_o    (face_n),
    .flag_o (flag),
    .ad_o   (ad),
    .abn_o  (abn),
    .au_o   (au),
    .av_o   (av)
  );

  // Vertex normals enter their normalizers together with the face normal.
  logic [VEC_W-1:0] gn_in [3];
  logic [GIVEN_W-1:0] given_d;

  rti_dly #(.W(3*VEC_W), .N(N_TAP)) u_gn_dly (
    .clk (clk),
    .en  (en),
    .d_i ({in_data.normal_c, in_data.normal_b, in_data.normal_a}),
    .q_o ({gn_in[2], gn_in[1], gn_in[0]})
  );

  rti_dly #(.W(GIVEN_W), .N(LN_TOT)) u_given_dly (
    .clk (clk),
    .en  (en),
    .d_i (in_data.normal_given),
    .q_o (given_d)
  );

  logic [3*NQ-1:0] face_u;
  logic [3*NQ-1:0] given_u [3];

  rti_nrm #(.IW(NW), .F(F)) u_nrm_face (
    .clk   (clk),
    .en    (en),
    .vec_i (face_n),
    .nrm_o (face_u)
  );

  for (genvar gj = 0; gj < 3; gj++) begin : g_nrm
    rti_nrm #(.IW(C), .F(F)) u_nrm (
      .clk   (clk),
      .en    (en),
      .vec_i (gn_in[gj][3*C-1:0]),
      .nrm_o (given_u[gj])
    );
  end

  // Distance: floor(|bn| * 2^16 / |d|), one quotient bit per stage. The
  // saturation flag covers every quotient that would need more than 32 bits.
  logic [DIST_W-1:0] tq;

  rti_div #(.DW(DDW), .QW(DIST_W)) u_div_t (
    .clk   (clk),
    .en    (en),
    .rem_i (DDW'(abn >> DIST_FRAC)),
    .lo_i  ({abn[DIST_FRAC-1:0], {(DIST_W-DIST_FRAC){1'b0}}}),
    .dv_i  (ad),
    .q_o   (tq)
  );

  // Barycentric weights |u|*2^F/|d| and |v|*2^F/|d|; on a hit both numerators
  // are bounded by |d|, so F+1 quotient bits hold them.
  logic [WQ-1:0] wu;
  logic [WQ-1:0] wv;

  rti_div #(.DW(DDW), .QW(WQ)) u_div_u (
    .clk   (clk),
    .en    (en),
    .rem_i (au >> 1),
    .lo_i  ({au[0], {F{1'b0}}}),
    .dv_i  (ad),
    .q_o   (wu)
  );

  rti_div #(.DW(DDW), .QW(WQ)) u_div_v (
    .clk   (clk),
    .en    (en),
    .rem_i (av >> 1),
    .lo_i  ({av[0], {F{1'b0}}}),
    .dv_i  (ad),
    .q_o   (wv)
  );

  // Align everything with the normalizer outputs and the blend stages.
  rti_flag_t     flag_d;
  logic [DIST_W-1:0] tq_d;
  logic [WQ-1:0] wu_d;
  logic [WQ-1:0] wv_d;

  rti_dly #(.W($bits(rti_flag_t)), .N(FLG_DLY)) u_flag_dly (
    .clk (clk),
    .en  (en),
    .d_i (flag),
    .q_o (flag_d)
  );

  rti_dly #(.W(DIST_W), .N(Q_DLY)) u_tq_dly (
    .clk (clk),
    .en  (en),
    .d_i (tq),
    .q_o (tq_d)
  );

  rti_dly #(.W(2*WQ), .N(WT_DLY)) u_w_dly (
    .clk (clk),
    .en  (en),
    .d_i ({wv, wu}),
    .q_o ({wv_d, wu_d})
  );

  // Blend stage 1: pick each vertex normal or the face normal, and form the
  // weight of corner a as what the other two leave of one.
  logic [WQ-1:0]        w_r  [3];
  logic signed [NQ-1:0] nv_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= (WQ'(1) << F) - wu_d - wv_d;
      w_r[1] <= wu_d;
      w_r[2] <= wv_d;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          nv_r[j][k] <= given_d[j] ? $signed(given_u[j][k*NQ +: NQ])
                                   : $signed(face_u[k*NQ +: NQ]);
        end
      end
    end
  end

  // Blend stage 2: the nine weight-by-lane products.
  logic signed [PRW-1:0] pr_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[k][j] <= $signed({1'b0, w_r[j]}) * nv_r[j][k];
        end
      end
    end
  end

  // Blend stage 3: sum, floor shift back to F fraction bits and pack. A miss
  // reports zero distance and a zero normal.
  logic signed [PRW+1:0] acc_s [3];
  logic signed [PRW+1:0] sh_s  [3];
  rti_out_t              lst_nxt;
  rti_out_t              lst_r;

  always_comb begin
    lst_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      acc_s[k] = (PRW+2)'(pr_r[k][0]) + (PRW+2)'(pr_r[k][1]) + (PRW+2)'(pr_r[k][2]);
      sh_s[k]  = acc_s[k] >>> F;
    end
    if (flag_d.hit) begin
      lst_nxt.hit      = 1'b1;
      lst_nxt.distance = flag_d.sat ? '1 : tq_d;
      for (int k = 0; k < 3; k++) begin
        lst_nxt.surface_normal[k*C +: C] = sh_s[k][C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst_r <= lst_nxt;
    end
  end

  // Output register with a one-entry skid register: the last stage can
  // retire into the skid while the consumer stalls, so the input side is
  // held off through a registered signal, the skid valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (sk_vld_r) begin
      if (!out_stall) begin
        out_vld_r  <= 1'b1;
        out_data_r <= sk_data_r;
        sk_vld_r   <= 1'b0;
      end
    end else if (out_vld_r && out_stall) begin
      if (vld_r[T_END-1]) begin
        sk_vld_r  <= 1'b1;
        sk_data_r <= lst_r;
      end
    end else begin
      out_vld_r  <= vld_r[T_END-1];
      out_data_r <= lst_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> (out_data.distance == '0) &&
                                   (out_data.surface_normal == '0))
    else $error("miss result carries nonzero payload");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_vld_r |-> out_vld_r)
    else $error("skid register holds a result while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_vld_r) |-> $past(out_stall) && $past(out_vld_r))
    else $error("skid register filled without a stalled output");

endmodule

### test/ray_triangle_intersect_top_tb.sv
// ----------------------------------------------------------------------------
// Ray/triangle intersector testbench
// Drives requests from a queue with random gaps and output stalls, predicts
// each result with an exact integer model and compares field by field.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rti_pkg::*;

  localparam int CB        = 21;            // bits per vector lane
  localparam int NF        = CB - 3;        // normal fraction bits
  localparam int RANDOM_N  = 800;
  localparam int CALM_TAIL = 150;           // last requests sent without gaps
  localparam int DRAIN_CYC = 120;           // idle drain after the last result
  localparam int LIMIT_CYC = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rti_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rti_out_t out_data;

  rti_in_t  ray_requests[$];       // requests waiting to be driven
  rti_out_t expected_hits[$];      // predicted results, oldest first
  int       errors = 0;
  int       hits_seen = 0;
  int       misses_seen = 0;
  int       cycles = 0;
  bit       req_taken = 1'b0;      // request accepted at the last rising edge
  int       send_gap = 0;
  int       stall_gap = 0;
  bit       calm = 1'b0;

  always #2 clk = ~clk;

  ray_triangle_intersect_top #(.COORD_BITS(CB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Appends a request to the end of the pending queue.
  function automatic void add_request(input rti_in_t r);
    ray_requests = {ray_requests, r};
  endfunction

  // ---------------------------------------------------------------------------
  // Exact integer predictor. Lanes are sign-extended into 64-bit integers, and
  // every product that can exceed 64 bits is formed at 128 bits.
  // ---------------------------------------------------------------------------
  function automatic void lanes_of(input logic [VEC_W-1:0] w, output longint c[3]);
    for (int k = 0; k < 3; k++) begin
      c[k] = longint'($signed(w[k*CB +: CB]));
    end
  endfunction

  function automatic logic [VEC_W-1:0] lanes_to(input longint c[3]);
    logic [VEC_W-1:0] w;
    for (int k = 0; k < 3; k++) begin
      w[k*CB +: CB] = c[k][CB-1:0];
    end
    return w;
  endfunction

  function automatic void cross_of(input longint a[3], input longint b[3],
                                   output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic signed [127:0] dot_of(input longint a[3], input longint b[3]);
    logic signed [127:0] acc;
    logic signed [127:0] x;
    logic signed [127:0] y;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      x = a[k];
      y = b[k];
      acc = acc + x * y;
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Unit vector with NF fraction bits; magnitudes are first brought below 2^30.
  function automatic void unit_of(input longint c[3], output longint o[3]);
    longint unsigned m[3];
    longint unsigned mx;
    longint unsigned sq;
    longint unsigned len;
    longint q;
    int s;
    mx = 0;
    sq = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = c[k] < 0 ? longint'(-c[k]) : c[k];
      if (m[k] > mx) mx = m[k];
    end
    while ((mx >> s) >= (64'd1 << 30)) s++;
    for (int k = 0; k < 3; k++) begin
      m[k] = m[k] >> s;
      sq = sq + m[k] * m[k];
    end
    len = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      q = (len == 0) ? 0 : longint'((m[k] << NF) / len);
      o[k] = c[k] < 0 ? -q : q;
    end
  endfunction

  function automatic rti_out_t predict_hit(input rti_in_t r);
    longint o[3], dv[3], pa[3], pb[3], pc[3], e1[3], e2[3], bv[3], n[3];
    longint cu[3], cv[3], nf[3], g[3], nv0[3], nv1[3], nv2[3];
    logic signed [127:0] d, u, v, uv, bn;
    logic [127:0] ad, q;
    longint wu, wv, w0, s;
    rti_out_t res;
    res = '0;
    lanes_of(r.ray_origin, o);
    lanes_of(r.ray_dir, dv);
    lanes_of(r.vertex_a, pa);
    lanes_of(r.vertex_b, pb);
    lanes_of(r.vertex_c, pc);
    for (int k = 0; k < 3; k++) begin
      e1[k] = pa[k] - pb[k];
      e2[k] = pa[k] - pc[k];
      bv[k] = pa[k] - o[k];
    end
    cross_of(e1, e2, n);
    d = dot_of(dv, n);
    // A ray parallel to the plane never hits.
    if (d == 0) return res;
    cross_of(bv, e2, cu);
    cross_of(e1, bv, cv);
    u = dot_of(dv, cu);
    v = dot_of(dv, cv);
    uv = u + v;
    if (d > 0) begin
      if (u < 0 || u > d || v < 0 || uv > d) return res;
    end else begin
      if (u > 0 || u < d || v > 0 || uv < d) return res;
    end
    bn = dot_of(bv, n);
    if (bn != 0 && ((bn < 0) != (d < 0))) return res;
    ad = d < 0 ? -d : d;
    q = ((bn < 0 ? -bn : bn) << DIST_FRAC) / ad;
    res.hit = 1'b1;
    res.distance = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    unit_of(n, nf);
    nv0 = nf;
    nv1 = nf;
    nv2 = nf;
    if (r.normal_given[0]) begin lanes_of(r.normal_a, g); unit_of(g, nv0); end
    if (r.normal_given[1]) begin lanes_of(r.normal_b, g); unit_of(g, nv1); end
    if (r.normal_given[2]) begin lanes_of(r.normal_c, g); unit_of(g, nv2); end
    q = ((u < 0 ? -u : u) << NF) / ad;
    wu = longint'(q[63:0]);
    q = ((v < 0 ? -v : v) << NF) / ad;
    wv = longint'(q[63:0]);
    w0 = (longint'(1) << NF) - wu - wv;
    for (int k = 0; k < 3; k++) begin
      s = wu * nv1[k] + wv * nv2[k] + w0 * nv0[k];
      res.surface_normal[k*CB +: CB] = CB'(s >>> NF);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders.
  // ---------------------------------------------------------------------------
  function automatic logic [VEC_W-1:0] rand_vec();
    return VEC_W'({$urandom, $urandom});
  endfunction

  function automatic longint rand_coord(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // A ray aimed at a barycentric point of the triangle: with weights summing
  // to wt, dir = sum(w_i * p_i) - wt * origin meets the plane at t = 1/wt.
  // Flipping the direction puts the triangle behind the origin.
  function automatic rti_in_t aimed_request(input int span, input bit flip);
    longint p[3][3];
    longint o[3], dv[3];
    int w[3];
    int wt;
    rti_in_t r;
    for (int j = 0; j < 3; j++) begin
      w[j] = $urandom_range(j == 0 ? 1 : 0, 10);
      for (int k = 0; k < 3; k++) p[j][k] = rand_coord(span);
    end
    wt = w[0] + w[1] + w[2];
    for (int k = 0; k < 3; k++) begin
      o[k] = rand_coord(span);
      dv[k] = w[0] * p[0][k] + w[1] * p[1][k] + w[2] * p[2][k] - wt * o[k];
      if (flip) dv[k] = -dv[k];
    end
    r.ray_origin = lanes_to(o);
    r.ray_dir = lanes_to(dv);
    r.vertex_a = lanes_to(p[0]);
    r.vertex_b = lanes_to(p[1]);
    r.vertex_c = lanes_to(p[2]);
    r.normal_a = rand_vec();
    r.normal_b = rand_vec();
    r.normal_c = rand_vec();
    r.normal_given = GIVEN_W'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic rti_in_t noise_request();
    rti_in_t r;
    r.ray_origin = rand_vec();
    r.ray_dir = rand_vec();
    r.vertex_a = rand_vec();
    r.vertex_b = rand_vec();
    r.vertex_c = rand_vec();
    r.normal_a = rand_vec();
    r.normal_b = rand_vec();
    r.normal_c = rand_vec();
    r.normal_given = GIVEN_W'($urandom_range(0, 7));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: requests and output stalls change on the falling edge. A presented
  // request is held until the rising edge that accepts it; idle bursts start
  // only while no request is presented.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || req_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(1, 19) - 1;
          in_valid <= 1'b0;
        end else if (ray_requests.size() > 0) begin
          in_data <= ray_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_gap <= $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts each accepted request and checks each accepted result
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rti_out_t want;
    cycles <= cycles + 1;
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_hits = {expected_hits, predict_hit(in_data)};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (want.hit) hits_seen++;
        else misses_seen++;
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %b, got %b", want.hit, out_data.hit);
          errors++;
        end
        if (out_data.distance !== want.distance) begin
          $error("distance: expected %h, got %h", want.distance, out_data.distance);
          errors++;
        end
        if (out_data.surface_normal !== want.surface_normal) begin
          $error("surface_normal: expected %h, got %h",
                 want.surface_normal, out_data.surface_normal);
          errors++;
        end
      end
    end
  end

  // The run is abandoned if it goes on far beyond the slowest correct pace.
  always @(posedge clk) begin
    if (cycles >= LIMIT_CYC) begin
      $display("timeout with %0d results outstanding", expected_hits.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    rti_in_t r;
    longint a[3], dv[3], o[3];

    // Directed requests. All-zero input: the determinant vanishes.
    add_request('0);
    // Every bit set: all lanes are -1, again a degenerate triangle.
    r = '1;
    add_request(r);
    // Lanes at the most positive and most negative values.
    r = noise_request();
    r.ray_dir = {3{21'h0FFFFF}};
    r.vertex_a = {21'h100000, 21'h0FFFFF, 21'h100000};
    r.vertex_b = {21'h0FFFFF, 21'h100000, 21'h100000};
    r.vertex_c = {3{21'h0FFFFF}};
    r.ray_origin = {3{21'h100000}};
    add_request(r);
    // Hits with every combination of supplied normals, extreme normal lanes.
    for (int i = 0; i < 8; i++) begin
      r = aimed_request(1 << 14, 1'b0);
      r.normal_given = GIVEN_W'(i);
      if (i == 3) r.normal_a = {3{21'h0FFFFF}};
      if (i == 5) r.normal_c = {3{21'h100000}};
      add_request(r);
    end
    // Supplied normals of zero length collapse to the zero vector.
    r = aimed_request(1 << 12, 1'b0);
    r.normal_given = 3'b111;
    r.normal_a = '0;
    r.normal_b = '0;
    r.normal_c = '0;
    add_request(r);
    // Triangle behind the origin.
    add_request(aimed_request(1 << 14, 1'b1));
    add_request(aimed_request(1 << 6, 1'b1));
    // Far hit: a unit step along z from 2^17 steps away saturates the distance.
    for (int i = 0; i < 3; i++) begin
      r = aimed_request(1 << 12, 1'b0);
      lanes_of(r.vertex_a, a);
      dv = '{0, 0, 1};
      o = '{a[0], a[1], a[2] - (longint'(1) << 17)};
      r.ray_dir = lanes_to(dv);
      r.ray_origin = lanes_to(o);
      add_request(r);
    end
    // Small triangles and a tiny direction.
    add_request(aimed_request(4, 1'b0));
    add_request(aimed_request(1, 1'b0));

    // Random part: mostly aimed rays of varied scale, the rest raw noise.
    for (int i = 0; i < RANDOM_N; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_request(noise_request());
        3:       add_request(aimed_request(1 << $urandom_range(0, 14), 1'b1));
        default: add_request(aimed_request(1 << $urandom_range(0, 14), 1'b0));
      endcase
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Drop the idle bursts near the end so the pipeline runs at full rate.
    wait (ray_requests.size() <= CALM_TAIL);
    calm = 1'b1;
    wait (ray_requests.size() == 0 && !in_valid);
    wait (expected_hits.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("checked %0d hits and %0d misses, including degenerate, far and",
             hits_seen, misses_seen);
    $display("behind-origin rays and every mix of supplied normals");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hdl/rti_pkg.sv
hdl/rti_dly.sv
hdl/rti_div.sv
hdl/rti_isqrt.sv
hdl/rti_nrm.sv
hdl/rti_geom.sv
hdl/ray_triangle_intersect_top.sv
test/ray_triangle_intersect_top_tb.sv
